// ===== rtl/mstb_pkg.sv =====
// Shared types and constants for the one-shot timer bank.
// No dependencies; imported by every module of the block except mstb_ram.
`default_nettype none

package mstb_pkg;

   localparam int OP_W  = 3;
   localparam int IDX_W = 4;
   localparam int VAL_W = 32;

   localparam logic [VAL_W-1:0] ALL_ONES = '1;

   // result kinds
   localparam logic KIND_EXPIRY = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_SET   = 3'd3,
      OP_QUERY = 3'd4
   } op_type;

   // one classified command, front to back
   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   slot;
      logic [VAL_W-1:0]   value;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/mstb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mstb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mstb_front.sv =====
// Front end: accepts request beats, drops ones that do nothing, queues the rest.
// Depends on mstb_pkg.
`default_nettype none

module mstb_front #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [mstb_pkg::OP_W-1:0]       req_operation,
   input  wire logic [mstb_pkg::IDX_W-1:0]      req_timer_index,
   input  wire logic [mstb_pkg::VAL_W-1:0]      req_value,
   output      logic                            cmd_valid,
   input  wire logic                            cmd_pop,
   output      mstb_pkg::cmd_type               cmd
);

   import mstb_pkg::*;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 slot_ok;
   logic                 keep;
   logic                 push;
   logic                 pop;
   cmd_type              entry;

   // classify: unused codes and out-of-range slots are dropped
   assign slot_ok = 32'(req_timer_index) < NUM_TIMERS;

   always_comb begin
      keep = 1'b0;
      unique case (req_operation)
         OP_TICK, OP_QUERY:        keep = 1'b1;
         OP_START, OP_STOP, OP_SET: keep = slot_ok;
         default:                  keep = 1'b0;
      endcase
   end

   assign entry.op    = op_type'(req_operation);
   assign entry.slot  = req_timer_index;
   assign entry.value = req_value;

   // queue control
   assign req_ready = cnt_ff != Q_CNT_W'(Q_DEPTH);
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = cnt_ff != '0;
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mstb_back.sv =====
// Back end: executes queued commands, keeps the tick count and slot state,
// scans slots on a tick and drives the response register. Depends on mstb_pkg
// and mstb_ram.
`default_nettype none

module mstb_back #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   output      logic                          cmd_pop,
   input  wire mstb_pkg::cmd_type             cmd,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_kind,
   output      logic [mstb_pkg::IDX_W-1:0]    rsp_expired_index,
   output      logic [mstb_pkg::VAL_W-1:0]    rsp_current_time,
   output      logic [mstb_pkg::VAL_W-1:0]    rsp_elapsed_time,
   output      logic                          rsp_last
);

   import mstb_pkg::*;

   localparam int SLOT_W = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W  = $clog2(NUM_TIMERS + 1);

   state_type             state_ff, state_in;
   logic [VAL_W-1:0]      tick_ff, tick_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [NUM_TIMERS-1:0] rld_vld_ff, rld_vld_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [SLOT_W-1:0]     pend_idx_ff, pend_idx_in;

   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [VAL_W-1:0]      rsp_now_ff, rsp_now_in;
   logic [VAL_W-1:0]      rsp_elapsed_ff, rsp_elapsed_in;
   logic                  rsp_last_ff, rsp_last_in;

   // RAM controls
   logic                  rld_we, rld_re;
   logic [SLOT_W-1:0]     rld_waddr, rld_raddr;
   logic [VAL_W-1:0]      rld_wdata, rld_rdata;
   logic                  dl_we, dl_re;
   logic [SLOT_W-1:0]     dl_waddr, dl_raddr;
   logic [VAL_W-1:0]      dl_wdata, dl_rdata;

   logic [SLOT_W-1:0]     slot;
   logic                  out_free;
   logic [VAL_W-1:0]      reload;
   logic [VAL_W-1:0]      elapsed;
   logic                  match;
   logic                  issue_left;

   mstb_ram #(.WIDTH(VAL_W), .DEPTH(NUM_TIMERS)) u_reload_ram (
      .clock   (clock),
      .wr_en   (rld_we),
      .wr_addr (rld_waddr),
      .wr_data (rld_wdata),
      .rd_en   (rld_re),
      .rd_addr (rld_raddr),
      .rd_data (rld_rdata)
   );

   mstb_ram #(.WIDTH(VAL_W), .DEPTH(NUM_TIMERS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_en   (dl_re),
      .rd_addr (dl_raddr),
      .rd_data (dl_rdata)
   );

   assign slot     = SLOT_W'(cmd.slot);
   assign out_free = !rsp_vld_ff || rsp_ready;

   // never-written reload entries read as zero
   assign reload = rld_vld_ff[cur_slot_ff] ? rld_rdata : '0;

   // wrap formula: saved ahead of now counts through all ones
   assign elapsed = (cmd.value > tick_ff) ? ALL_ONES - cmd.value + tick_ff
                                          : tick_ff - cmd.value;

   // scan compare on the registered deadline read of slot cmp_idx_ff
   assign match      = cmp_vld_ff && armed_ff[cmp_idx_ff] && (dl_rdata == tick_ff);
   assign issue_left = cnt_ff < CNT_W'(NUM_TIMERS);

   // sequencer: next state, slot updates and response
   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      armed_in       = armed_ff;
      rld_vld_in     = rld_vld_ff;
      cur_slot_in    = cur_slot_ff;
      cnt_in         = cnt_ff;
      cmp_vld_in     = cmp_vld_ff;
      cmp_idx_in     = cmp_idx_ff;
      pend_vld_in    = pend_vld_ff;
      pend_idx_in    = pend_idx_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_now_in     = rsp_now_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_last_in    = rsp_last_ff;
      cmd_pop        = 1'b0;
      rld_we         = 1'b0;
      rld_waddr      = slot;
      rld_wdata      = cmd.value;
      rld_re         = 1'b0;
      rld_raddr      = slot;
      dl_we          = 1'b0;
      dl_waddr       = slot;
      dl_wdata       = cmd.value;
      dl_re          = 1'b0;
      dl_raddr       = cnt_ff[SLOT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_TICK: begin
                     cmd_pop     = 1'b1;
                     tick_in     = tick_ff + 1'b1;
                     cnt_in      = '0;
                     cmp_vld_in  = 1'b0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  OP_START: begin
                     cmd_pop     = 1'b1;
                     rld_re      = 1'b1;
                     cur_slot_in = slot;
                     state_in    = ST_START;
                  end
                  OP_STOP: begin
                     cmd_pop        = 1'b1;
                     armed_in[slot] = 1'b0;
                  end
                  OP_SET: begin
                     cmd_pop          = 1'b1;
                     rld_we           = 1'b1;
                     dl_we            = 1'b1;
                     rld_vld_in[slot] = 1'b1;
                     armed_in[slot]   = 1'b0;
                  end
                  OP_QUERY: begin
                     if (out_free) begin
                        cmd_pop        = 1'b1;
                        rsp_vld_in     = 1'b1;
                        rsp_kind_in    = KIND_QUERY;
                        rsp_idx_in     = '0;
                        rsp_now_in     = tick_ff;
                        rsp_elapsed_in = elapsed;
                        rsp_last_in    = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end

         // reload data is back: arm unless it is zero
         ST_START: begin
            if (reload != '0) begin
               dl_we                 = 1'b1;
               dl_waddr              = cur_slot_ff;
               dl_wdata              = reload + tick_ff;
               armed_in[cur_slot_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end

         // one slot a cycle unless a hit waits on a busy response; the latest hit is held back so last can be set
         ST_SCAN: begin
            if (!cmp_vld_ff && !issue_left) begin
               if (!pend_vld_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_vld_in     = 1'b1;
                  rsp_kind_in    = KIND_EXPIRY;
                  rsp_idx_in     = IDX_W'(pend_idx_ff);
                  rsp_now_in     = tick_ff;
                  rsp_elapsed_in = '0;
                  rsp_last_in    = 1'b1;
                  pend_vld_in    = 1'b0;
                  state_in       = ST_IDLE;
               end
            end else if (!(match && pend_vld_ff && !out_free)) begin
               if (match) begin
                  armed_in[cmp_idx_ff] = 1'b0;
                  if (pend_vld_ff) begin
                     rsp_vld_in     = 1'b1;
                     rsp_kind_in    = KIND_EXPIRY;
                     rsp_idx_in     = IDX_W'(pend_idx_ff);
                     rsp_now_in     = tick_ff;
                     rsp_elapsed_in = '0;
                     rsp_last_in    = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_idx_in = cmp_idx_ff;
               end
               if (issue_left) begin
                  dl_re      = 1'b1;
                  cmp_vld_in = 1'b1;
                  cmp_idx_in = cnt_ff[SLOT_W-1:0];
                  cnt_in     = cnt_ff + 1'b1;
               end else begin
                  cmp_vld_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tick_ff     <= '0;
         armed_ff    <= '0;
         rld_vld_ff  <= '0;
         cnt_ff      <= '0;
         cmp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         armed_ff    <= armed_in;
         rld_vld_ff  <= rld_vld_in;
         cnt_ff      <= cnt_in;
         cmp_vld_ff  <= cmp_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_slot_ff    <= cur_slot_in;
      cmp_idx_ff     <= cmp_idx_in;
      pend_idx_ff    <= pend_idx_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_now_ff     <= rsp_now_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_expired_index = rsp_idx_ff;
   assign rsp_current_time  = rsp_now_ff;
   assign rsp_elapsed_time  = rsp_elapsed_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/multi_slot_oneshot_timer_bank_top.sv =====
// One-shot timer bank: a two-deep request queue (mstb_front) feeding the executor (mstb_back).
// Back end: stop, set and query are handled in idle; start reads the reload RAM, then arms;
// a tick scans all slots with one deadline RAM read per slot; expiries leave one per cycle
// while rsp_ready is high. Synchronous reset clears tick count, armed and reload-valid
// flags and the queue; no clearing pass, requests are taken right after reset.
// Depends on mstb_pkg, mstb_front, mstb_back.
`default_nettype none

module multi_slot_oneshot_timer_bank_top #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [mstb_pkg::OP_W-1:0]     req_operation,
   input  wire logic [mstb_pkg::IDX_W-1:0]    req_timer_index,
   input  wire logic [mstb_pkg::VAL_W-1:0]    req_value,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_kind,
   output      logic [mstb_pkg::IDX_W-1:0]    rsp_expired_index,
   output      logic [mstb_pkg::VAL_W-1:0]    rsp_current_time,
   output      logic [mstb_pkg::VAL_W-1:0]    rsp_elapsed_time,
   output      logic                          rsp_last
);

   import mstb_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   mstb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_timer_index (req_timer_index),
      .req_value       (req_value),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd)
   );

   mstb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_expired_index (rsp_expired_index),
      .rsp_current_time  (rsp_current_time),
      .rsp_elapsed_time  (rsp_elapsed_time),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/mstb_checker.sv =====
// Port-level checks for the timer bank, bound to the top level.
// Depends on mstb_pkg.
`default_nettype none

module mstb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_kind,
   input wire logic [mstb_pkg::IDX_W-1:0]    rsp_expired_index,
   input wire logic [mstb_pkg::VAL_W-1:0]    rsp_current_time,
   input wire logic [mstb_pkg::VAL_W-1:0]    rsp_elapsed_time,
   input wire logic                          rsp_last
);

   import mstb_pkg::*;

   // response beat is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped before accept");

   // stalled response payload holds, elapsed time apart
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_current_time) && $stable(rsp_kind)
                                  && $stable(rsp_expired_index) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // a query answer is a single beat with no slot
   a_query_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_QUERY |-> rsp_last && rsp_expired_index == '0)
      else $error("malformed query answer");

   // an expiry carries no elapsed time
   a_expiry_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EXPIRY |-> rsp_elapsed_time == '0)
      else $error("expiry with nonzero elapsed time");

   // no response is valid right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind multi_slot_oneshot_timer_bank_top mstb_checker u_mstb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_expired_index (rsp_expired_index),
   .rsp_current_time  (rsp_current_time),
   .rsp_elapsed_time  (rsp_elapsed_time),
   .rsp_last          (rsp_last)
);

`default_nettype wire
